[sv/mpq_pkg.sv]
// Package for the max-priority queue: status codes, operation codes and widths.
// Used by the channel interfaces and by max_priority_queue_top; depends on nothing.

package mpq_pkg;

  localparam int unsigned ValueW = 32;

  // Operation carried in the mode field of a request.
  localparam logic ModeInsert  = 1'b0;
  localparam logic ModeExtract = 1'b1;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StExtracted = 2'd1,
    StEmpty     = 2'd2,
    StFull      = 2'd3
  } mpq_status_e;

endpackage

[sv/mpq_intf.sv]
// Valid/ready channel interfaces of the max-priority queue: request and response.
// Depends on mpq_pkg for the value width.

interface mpq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [mpq_pkg::ValueW-1:0]    value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface mpq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [mpq_pkg::ValueW-1:0]    max_value;

  modport source (output valid, output status, output max_value, input ready);
  modport sink (input valid, input status, input max_value, output ready);
endinterface

[sv/max_priority_queue_top.sv]
// Bounded max-priority queue of signed 32-bit values, top level.
// Depends on mpq_pkg and on the interfaces in mpq_intf.sv.
//
// Usage: a request transaction on req_i either inserts value (mode 0) or
// extracts the greatest stored value (mode 1). Every request yields exactly
// one response transaction on rsp_o with a status (inserted, extracted, empty
// on extract, full with the insert dropped) and max_value, which carries the
// extracted maximum and is zero for every other status.
// Latency: an insert, a full insert and an empty extract answer in the cycle after
// acceptance. An extract from a queue of N entries scans the store one entry a
// cycle through its single registered read port and one signed comparator, and
// answers from S_WRITE, where the last entry moves into the hole.
// Throughput: one request at a time; req_i.ready is high only while the
// sequencer is idle and the response register is empty, so a stalled receiver
// holds the response and blocks the next request until it is taken.
// Reset: rst_ni clears the entry count and the control state; the queue is
// empty at once and the store contents need no clearing.

module max_priority_queue_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpq_req_if.sink     req_i,
  mpq_rsp_if.source   rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned VW   = mpq_pkg::ValueW;
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);
  localparam logic [CntW-1:0] ZeroCnt = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        rd_addr_q, rd_addr_d;
  logic [CntW-1:0]        data_idx_q, data_idx_d;
  logic                   data_vld_q, data_vld_d;
  logic signed [VW-1:0]   best_val_q, best_val_d;
  logic [IdxW-1:0]        best_idx_q, best_idx_d;
  logic                   best_vld_q, best_vld_d;
  logic [VW-1:0]          last_val_q, last_val_d;
  logic                   out_vld_q, out_vld_d;
  mpq_pkg::mpq_status_e   out_status_q, out_status_d;
  logic signed [VW-1:0]   out_max_q, out_max_d;

  logic [VW-1:0]          mem_q [CAPACITY];
  logic [VW-1:0]          rdata_q;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  logic [VW-1:0]          wr_data;
  logic                   req_accept;

  assign req_i.ready     = (state_q == S_IDLE) && !out_vld_q;
  assign req_accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.max_value = out_max_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_addr_d    = rd_addr_q;
    data_idx_d   = data_idx_q;
    data_vld_d   = 1'b0;
    best_val_d   = best_val_q;
    best_idx_d   = best_idx_q;
    best_vld_d   = best_vld_q;
    last_val_d   = last_val_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_max_d    = out_max_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[IdxW-1:0];
    wr_data      = req_i.value;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          out_max_d = '0;
          if (req_i.mode == mpq_pkg::ModeInsert) begin
            out_vld_d = 1'b1;
            if (count_q == CapCnt) begin
              out_status_d = mpq_pkg::StFull;
            end else begin
              wr_en        = 1'b1;
              count_d      = count_q + OneCnt;
              out_status_d = mpq_pkg::StInserted;
            end
          end else if (count_q == ZeroCnt) begin
            out_vld_d    = 1'b1;
            out_status_d = mpq_pkg::StEmpty;
          end else begin
            state_d    = S_SCAN;
            rd_addr_d  = ZeroCnt;
            best_vld_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued in the cycle before their data is compared.
        if (rd_addr_q < count_q) begin
          rd_addr_d  = rd_addr_q + OneCnt;
          data_idx_d = rd_addr_q;
          data_vld_d = 1'b1;
        end
        if (data_vld_q) begin
          if (!best_vld_q || ($signed(rdata_q) > best_val_q)) begin
            best_val_d = $signed(rdata_q);
            best_idx_d = data_idx_q[IdxW-1:0];
            best_vld_d = 1'b1;
          end
          // The last entry moves into the hole left by the extracted maximum.
          if (data_idx_q == (count_q - OneCnt)) begin
            last_val_d = rdata_q;
            state_d    = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        wr_en        = 1'b1;
        wr_addr      = best_idx_q;
        wr_data      = last_val_q;
        count_d      = count_q - OneCnt;
        out_vld_d    = 1'b1;
        out_status_d = mpq_pkg::StExtracted;
        out_max_d    = best_val_q;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_addr_q    <= '0;
      data_vld_q   <= 1'b0;
      best_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      out_status_q <= mpq_pkg::StInserted;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_addr_q    <= rd_addr_d;
      data_vld_q   <= data_vld_d;
      best_vld_q   <= best_vld_d;
      out_vld_q    <= out_vld_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_idx_q <= data_idx_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    last_val_q <= last_val_d;
    out_max_q  <= out_max_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count exceeds capacity");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> (state_q == S_IDLE) && !out_vld_q)
    else $error("request accepted while busy");

  a_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_status_q != mpq_pkg::StExtracted) |-> out_max_q == '0)
    else $error("nonzero max_value on a response without extraction");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> (state_q == S_SCAN) && (data_idx_q < count_q))
    else $error("scan data index outside the stored entries");

  a_extract_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) && (out_status_q == mpq_pkg::StExtracted)
      |-> count_q == CntW'($past(count_q) - OneCnt))
    else $error("extraction did not remove exactly one entry");

endmodule

[verif/max_priority_queue_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for max_priority_queue_top: insert and extract-max traffic.
// Depends on mpq_pkg, the channel interfaces in mpq_intf.sv and the top level RTL.

module max_priority_queue_top_test;

  localparam int unsigned QueueDepth  = 64;
  localparam int unsigned DrainCycles = QueueDepth + 8;
  localparam int unsigned LimitCycles = 1_000_000;
  localparam int unsigned PrintLimit  = 40;

  typedef struct {
    mpq_pkg::mpq_status_e              status;
    logic signed [mpq_pkg::ValueW-1:0] max_value;
  } queue_result_t;

  logic clk;
  logic rst_n;

  mpq_req_if req_if ();
  mpq_rsp_if rsp_if ();

  max_priority_queue_top #(
    .CAPACITY (QueueDepth)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the queue contents and the responses still owed by the block.
  logic signed [mpq_pkg::ValueW-1:0] shadow_store [QueueDepth];
  int unsigned                       shadow_count;
  queue_result_t                     pending_results [$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned rsp_hold_cycles;
  bit          req_idle_en;
  bit          rsp_idle_en;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("max_priority_queue_top_test: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Applies one operation to the shadow queue and returns the response it must produce.
  function automatic queue_result_t apply_queue_op(
    input logic op,
    input logic signed [mpq_pkg::ValueW-1:0] val
  );
    queue_result_t res;
    int unsigned   top_idx;
    res.status    = mpq_pkg::StInserted;
    res.max_value = '0;
    if (op == mpq_pkg::ModeInsert) begin
      if (shadow_count >= QueueDepth) begin
        res.status = mpq_pkg::StFull;
      end else begin
        shadow_store[shadow_count] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = mpq_pkg::StEmpty;
    end else begin
      top_idx = 0;
      for (int unsigned i = 1; i < shadow_count; i++) begin
        if (shadow_store[i] > shadow_store[top_idx]) top_idx = i;
      end
      res.status    = mpq_pkg::StExtracted;
      res.max_value = shadow_store[top_idx];
      shadow_count--;
      shadow_store[top_idx] = shadow_store[shadow_count];
    end
    return res;
  endfunction

  // Mostly full-range values, with clusters of small ones so that duplicates are common.
  function automatic logic signed [mpq_pkg::ValueW-1:0] pick_value();
    logic signed [mpq_pkg::ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = $signed($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_request(input logic op, input logic signed [mpq_pkg::ValueW-1:0] val);
    int unsigned gap;
    gap = req_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= op;
    req_if.value <= val;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_queue_op(op, val));
  endtask

  // Stops offering requests and waits until every response has been taken.
  task automatic finish_phase();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Response side: a random stall before each transaction, plus an occasional long hold-off.
  initial begin : response_side
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (rsp_hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end
      stall = rsp_idle_en ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  always @(posedge clk) begin : response_check
    queue_result_t exp;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d max_value=%0d",
                                  rsp_if.status, rsp_if.max_value));
      end else begin
        exp = pending_results.pop_front();
        if (rsp_if.status !== exp.status) begin
          report_mismatch($sformatf("status %0d, expected %s", rsp_if.status,
                                    exp.status.name()));
        end
        if (rsp_if.max_value !== exp.max_value) begin
          report_mismatch($sformatf("max_value %0d, expected %0d", rsp_if.max_value,
                                    exp.max_value));
        end
      end
    end
  end

  task automatic test_empty_extract();
    send_request(mpq_pkg::ModeExtract, 32'sh7fff_ffff);
    send_request(mpq_pkg::ModeExtract, 32'sh8000_0000);
    finish_phase();
  endtask

  // The two extremes together toggle every value bit both ways.
  task automatic test_value_extremes();
    send_request(mpq_pkg::ModeInsert, 0);
    send_request(mpq_pkg::ModeInsert, 32'sh8000_0000);
    send_request(mpq_pkg::ModeInsert, 32'sh7fff_ffff);
    send_request(mpq_pkg::ModeInsert, -1);
    send_request(mpq_pkg::ModeInsert, 1);
    repeat (6) send_request(mpq_pkg::ModeExtract, $urandom());
    finish_phase();
  endtask

  task automatic test_equal_values();
    send_request(mpq_pkg::ModeInsert, 5);
    send_request(mpq_pkg::ModeInsert, 5);
    send_request(mpq_pkg::ModeInsert, -3);
    send_request(mpq_pkg::ModeInsert, 5);
    send_request(mpq_pkg::ModeInsert, -3);
    repeat (5) send_request(mpq_pkg::ModeExtract, 0);
    finish_phase();
  endtask

  // Fills the store past capacity while the receiver holds off, so requests back up.
  task automatic test_full_store();
    rsp_hold_cycles = 300;
    repeat (QueueDepth + 3) send_request(mpq_pkg::ModeInsert, pick_value());
    repeat (2) send_request(mpq_pkg::ModeExtract, $urandom());
    repeat (2) send_request(mpq_pkg::ModeInsert, pick_value());
    finish_phase();
  endtask

  // The insert share changes every few dozen requests so the fill level sweeps the whole range.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 92;
        endcase
        req_idle_en = ($urandom_range(0, 3) != 0);
        rsp_idle_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(1, 100) <= insert_pct) begin
        send_request(mpq_pkg::ModeInsert, pick_value());
      end else begin
        send_request(mpq_pkg::ModeExtract, $urandom());
      end
    end
    finish_phase();
  endtask

  initial begin
    error_count     = 0;
    cycle_count     = 0;
    shadow_count    = 0;
    rsp_hold_cycles = 0;
    req_idle_en     = 1'b1;
    rsp_idle_en     = 1'b1;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode  <= mpq_pkg::ModeInsert;
    req_if.value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_extract();
    test_value_extremes();
    test_equal_values();
    test_full_store();
    test_random_traffic(1860);

    if (error_count == 0) begin
      $display("max_priority_queue_top_test: done, clean");
    end else begin
      $display("max_priority_queue_top_test: done, errors");
    end
    $finish;
  end

endmodule

[max_priority_queue_top.f]
sv/mpq_pkg.sv
sv/mpq_intf.sv
sv/max_priority_queue_top.sv
verif/max_priority_queue_top_test.sv
